FILE: design/tps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types and constants of the timer pool scheduler.
// ----------------------------------------------------------------------------
package tps_pkg;

    // pool size and derived slot index width
    localparam int POOL_SLOTS = 16;
    localparam int SLOT_W     = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

    // command queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // input mode codes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_CANCEL = 2'd1;
    localparam logic [1:0] MODE_TICK   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // result kind codes
    localparam logic [2:0] KIND_STARTED = 3'd0;
    localparam logic [2:0] KIND_FULL    = 3'd1;
    localparam logic [2:0] KIND_FIRED   = 3'd2;
    localparam logic [2:0] KIND_SCAN    = 3'd3;
    localparam logic [2:0] KIND_CANCEL  = 3'd4;

    // classified command
    typedef enum logic [1:0] {
        OP_START,
        OP_CANCEL,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [7:0]  timer_id;
        logic [31:0] timeout_ticks;
        logic        periodic;
        logic        has_callback;
    } t_cmd;

    // back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_eng_state;

endpackage

FILE: design/timer_pool_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_pool_scheduler
// Pool of timer slots driven by start, cancel and tick transactions.
//
//   channel  handshake           payload
//   input    i_valid / o_ready   i_mode, i_timer_id, i_timeout_ticks,
//                                i_periodic, i_has_callback
//   output   o_valid / i_ready   o_kind, o_fired_id, o_found, o_last
//
// Start and cancel are executed directly from idle; a tick runs a scan that
// visits one slot per cycle while the output is not stalled.
// A two-entry command queue lets the front take transactions while the back
// end scans. Synchronous active-low reset clears the count and all slots at
// once; no clearing pass is needed. A stalled output holds the scan on the
// slot that fires until the pending result is taken.
// ----------------------------------------------------------------------------
module timer_pool_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_timer_id,
    input  logic [31:0] i_timeout_ticks,
    input  logic        i_periodic,
    input  logic        i_has_callback,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_fired_id,
    output logic        o_found,
    output logic        o_last
);

    logic          cmd_valid;
    tps_pkg::t_cmd cmd;
    logic          cmd_pop;

    // front: accept and classify
    tps_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_mode          (i_mode),
        .i_timer_id      (i_timer_id),
        .i_timeout_ticks (i_timeout_ticks),
        .i_periodic      (i_periodic),
        .i_has_callback  (i_has_callback),
        .o_cmd_valid     (cmd_valid),
        .o_cmd           (cmd),
        .i_cmd_pop       (cmd_pop)
    );

    // back: slot state and scan
    tps_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_kind      (o_kind),
        .o_fired_id  (o_fired_id),
        .o_found     (o_found),
        .o_last      (o_last)
    );

endmodule

FILE: design/tps_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_front
// Accepts input transactions, classifies the mode and queues commands for
// the back end. Unused mode codes are accepted and dropped here.
// ----------------------------------------------------------------------------
module tps_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_mode,
    input  logic [7:0]    i_timer_id,
    input  logic [31:0]   i_timeout_ticks,
    input  logic          i_periodic,
    input  logic          i_has_callback,
    output logic          o_cmd_valid,
    output tps_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    tps_pkg::t_cmd                  r_mem [tps_pkg::Q_DEPTH];
    logic [tps_pkg::Q_PTR_W-1:0]    r_wr_ptr;
    logic [tps_pkg::Q_PTR_W-1:0]    r_rd_ptr;
    logic [tps_pkg::Q_CNT_W-1:0]    r_count;
    logic [tps_pkg::Q_CNT_W-1:0]    n_count;

    tps_pkg::t_cmd                  in_cmd;
    logic                           in_keep;
    logic                           push;
    logic                           pop;

    // classify the incoming mode
    always_comb begin
        in_cmd.timer_id      = i_timer_id;
        in_cmd.timeout_ticks = i_timeout_ticks;
        in_cmd.periodic      = i_periodic;
        in_cmd.has_callback  = i_has_callback;
        in_cmd.op            = tps_pkg::OP_TICK;
        in_keep              = 1'b1;
        unique case (i_mode)
            tps_pkg::MODE_START:  in_cmd.op = tps_pkg::OP_START;
            tps_pkg::MODE_CANCEL: in_cmd.op = tps_pkg::OP_CANCEL;
            tps_pkg::MODE_TICK:   in_cmd.op = tps_pkg::OP_TICK;
            default:              in_keep   = 1'b0;
        endcase
    end

    assign o_ready     = (r_count != tps_pkg::Q_CNT_W'(tps_pkg::Q_DEPTH));
    assign push        = i_valid && o_ready && in_keep;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_mem[r_rd_ptr];

    // occupancy
    always_comb begin
        unique case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= in_cmd;
        end
    end

endmodule

FILE: design/tps_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_engine
// Back end: holds the timer slots and the tick count, executes start and
// cancel from idle, and walks the slots one per cycle on a tick while the
// output is not stalled. Results leave through a registered output stage.
// ----------------------------------------------------------------------------
module tps_engine (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  tps_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [2:0]    o_kind,
    output logic [7:0]    o_fired_id,
    output logic          o_found,
    output logic          o_last
);

    localparam int NS = tps_pkg::POOL_SLOTS;
    localparam int SW = tps_pkg::SLOT_W;

    // slot state
    logic [NS-1:0]   r_used;
    logic [7:0]      r_ident   [NS];
    logic [31:0]     r_start   [NS];
    logic [31:0]     r_timeout [NS];
    logic [NS-1:0]   r_periodic;
    logic [NS-1:0]   r_notify;
    logic [NS-1:0]   r_cancel;

    logic [31:0]          r_now;
    logic [31:0]          n_now;
    tps_pkg::t_eng_state  r_state;
    tps_pkg::t_eng_state  n_state;
    logic [SW-1:0]        r_idx;
    logic [SW-1:0]        n_idx;

    // output stage
    logic       r_out_valid;
    logic [2:0] r_kind;
    logic [7:0] r_fired_id;
    logic       r_found;
    logic       r_last;

    logic       out_free;
    logic       out_load;
    logic [2:0] out_kind;
    logic [7:0] out_id;
    logic       out_found;
    logic       out_last;

    // slot search
    logic [NS-1:0] match;
    logic          hit;
    logic [SW-1:0] hit_slot;
    logic          has_free;
    logic [SW-1:0] free_slot;
    logic [SW-1:0] sel_slot;

    // scan datapath
    logic [31:0] elapsed;
    logic        expired;

    // slot update actions
    logic do_start;
    logic do_cancel;
    logic do_free;
    logic do_rearm;

    // id match and priority encoders, lowest slot wins
    always_comb begin
        hit       = 1'b0;
        hit_slot  = '0;
        has_free  = 1'b0;
        free_slot = '0;
        for (int i = NS - 1; i >= 0; i--) begin
            match[i] = r_used[i] && (r_ident[i] == i_cmd.timer_id);
            if (match[i]) begin
                hit      = 1'b1;
                hit_slot = SW'(i);
            end
            if (!r_used[i]) begin
                has_free  = 1'b1;
                free_slot = SW'(i);
            end
        end
        sel_slot = hit ? hit_slot : free_slot;
    end

    // expiry test of the slot under the scan pointer
    assign elapsed  = r_now - r_start[r_idx];
    assign expired  = (elapsed >= r_timeout[r_idx]);
    assign out_free = !r_out_valid || i_ready;

    // sequencer: next state and actions
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_now     = r_now;
        o_cmd_pop = 1'b0;
        out_load  = 1'b0;
        out_kind  = tps_pkg::KIND_SCAN;
        out_id    = '0;
        out_found = 1'b0;
        out_last  = 1'b1;
        do_start  = 1'b0;
        do_cancel = 1'b0;
        do_free   = 1'b0;
        do_rearm  = 1'b0;
        unique case (r_state)
            tps_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        tps_pkg::OP_START: begin
                            if (out_free) begin
                                o_cmd_pop = 1'b1;
                                out_load  = 1'b1;
                                out_id    = i_cmd.timer_id;
                                if (hit || has_free) begin
                                    do_start = 1'b1;
                                    out_kind = tps_pkg::KIND_STARTED;
                                end else begin
                                    out_kind = tps_pkg::KIND_FULL;
                                end
                            end
                        end
                        tps_pkg::OP_CANCEL: begin
                            if (out_free) begin
                                o_cmd_pop = 1'b1;
                                out_load  = 1'b1;
                                out_id    = i_cmd.timer_id;
                                out_kind  = tps_pkg::KIND_CANCEL;
                                out_found = hit;
                                do_cancel = hit;
                            end
                        end
                        default: begin
                            // tick: advance the count, then scan
                            o_cmd_pop = 1'b1;
                            n_now     = r_now + 32'd1;
                            n_idx     = '0;
                            n_state   = tps_pkg::ST_SCAN;
                        end
                    endcase
                end
            end
            tps_pkg::ST_SCAN: begin
                if (r_used[r_idx] && !r_cancel[r_idx] && expired && r_notify[r_idx]
                    && !out_free) begin
                    // fire result must wait for the output stage
                    n_state = r_state;
                end else begin
                    if (r_used[r_idx]) begin
                        if (r_cancel[r_idx]) begin
                            do_free = 1'b1;
                        end else if (expired) begin
                            if (r_notify[r_idx]) begin
                                out_load = 1'b1;
                                out_kind = tps_pkg::KIND_FIRED;
                                out_id   = r_ident[r_idx];
                                out_last = 1'b0;
                            end
                            do_rearm = r_periodic[r_idx];
                            do_free  = !r_periodic[r_idx];
                        end
                    end
                    if (r_idx == SW'(NS - 1)) begin
                        n_state = tps_pkg::ST_DONE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                // closing scan-done result
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = tps_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tps_pkg::ST_IDLE;
            r_idx   <= '0;
            r_now   <= '0;
            r_used  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_now   <= n_now;
            if (do_start) begin
                r_used[sel_slot] <= 1'b1;
            end
            if (do_free) begin
                r_used[r_idx] <= 1'b0;
            end
        end
    end

    // slot payload
    always_ff @(posedge i_clk) begin
        if (do_start) begin
            r_ident[sel_slot]    <= i_cmd.timer_id;
            r_start[sel_slot]    <= r_now;
            r_timeout[sel_slot]  <= i_cmd.timeout_ticks;
            r_periodic[sel_slot] <= i_cmd.periodic;
            r_notify[sel_slot]   <= i_cmd.has_callback;
            r_cancel[sel_slot]   <= 1'b0;
        end
        if (do_cancel) begin
            r_cancel[hit_slot] <= 1'b1;
        end
        if (do_rearm) begin
            r_start[r_idx] <= r_now;
        end
    end

    // output stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output stage payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_kind     <= out_kind;
            r_fired_id <= out_id;
            r_found    <= out_found;
            r_last     <= out_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_kind;
    assign o_fired_id = r_fired_id;
    assign o_found    = r_found;
    assign o_last     = r_last;

endmodule

FILE: dv/tb_timer_pool_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timer_pool_scheduler
// Self-checking bench for the timer pool scheduler. A directed table covers
// an empty-pool tick, unknown cancels, restart of a known id, one-shot and
// periodic expiry, silent frees, a full pool and a wide fire burst. Random
// start/cancel/tick traffic follows, under several idle and stall patterns
// and one long output hold-off. Every result is checked against its
// hand-written answer or a cycle-free slot pool model kept in the bench.
// ----------------------------------------------------------------------------
module tb_timer_pool_scheduler;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 16;

    // one input transaction, with an optional hand-written answer
    typedef struct {
        logic [1:0]  mode;
        logic [7:0]  timer_id;
        logic [31:0] timeout_ticks;
        logic        periodic;
        logic        has_callback;
        bit          typed;
        logic [2:0]  t_kind;
        logic [7:0]  t_id;
        logic        t_found;
    } t_txn;

    // directed row; rep > 1 repeats it with the id counting up
    typedef struct {
        t_txn txn;
        int   rep;
    } t_dir_row;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] fired_id;
        logic       found;
        logic       last;
    } t_result;

    // DUT signals
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode          = tps_pkg::MODE_NONE;
    logic [7:0]  i_timer_id      = '0;
    logic [31:0] i_timeout_ticks = '0;
    logic        i_periodic      = 1'b0;
    logic        i_has_callback  = 1'b0;
    logic        o_valid;
    logic        i_ready         = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_fired_id;
    logic        o_found;
    logic        o_last;

    // pool model state
    logic [31:0] now_cnt;
    logic        pool_used    [tps_pkg::POOL_SLOTS];
    logic [7:0]  pool_ident   [tps_pkg::POOL_SLOTS];
    logic [31:0] pool_start   [tps_pkg::POOL_SLOTS];
    logic [31:0] pool_timeout [tps_pkg::POOL_SLOTS];
    logic        pool_periodic[tps_pkg::POOL_SLOTS];
    logic        pool_notify  [tps_pkg::POOL_SLOTS];
    logic        pool_cancel  [tps_pkg::POOL_SLOTS];

    t_result  step_results[$];
    t_result  pending_results[$];
    t_dir_row dir_tbl[$];

    int  fail_count     = 0;
    int  cycle_cnt      = 0;
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  hold_left      = 0;
    bit  hold_pending   = 1'b0;

    timer_pool_scheduler u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_timer_id     (i_timer_id),
        .i_timeout_ticks(i_timeout_ticks),
        .i_periodic     (i_periodic),
        .i_has_callback (i_has_callback),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_kind         (o_kind),
        .o_fired_id     (o_fired_id),
        .o_found        (o_found),
        .o_last         (o_last)
    );

    // 2 ns clock
    always #1 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // pool model
    // ------------------------------------------------------------------
    task automatic clear_pool();
        int i;
        now_cnt = '0;
        for (i = 0; i < tps_pkg::POOL_SLOTS; i++) begin
            pool_used[i]     = 1'b0;
            pool_ident[i]    = '0;
            pool_start[i]    = '0;
            pool_timeout[i]  = '0;
            pool_periodic[i] = 1'b0;
            pool_notify[i]   = 1'b0;
            pool_cancel[i]   = 1'b0;
        end
    endtask

    function automatic int find_slot(logic [7:0] id);
        int i;
        for (i = 0; i < tps_pkg::POOL_SLOTS; i++)
            if (pool_used[i] && pool_ident[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void add_result(logic [2:0] kind, logic [7:0] id,
                                       logic found, logic last);
        t_result r;
        r.kind     = kind;
        r.fired_id = id;
        r.found    = found;
        r.last     = last;
        step_results.push_back(r);
    endfunction

    // advances the pool by one transaction and lists the results it causes
    task automatic pool_step(input t_txn t);
        int          i;
        int          slot;
        logic [31:0] elapsed;
        step_results.delete();
        case (t.mode)
            tps_pkg::MODE_START: begin
                slot = find_slot(t.timer_id);
                if (slot < 0) begin
                    for (i = tps_pkg::POOL_SLOTS - 1; i >= 0; i--)
                        if (!pool_used[i])
                            slot = i;
                end
                if (slot < 0) begin
                    add_result(tps_pkg::KIND_FULL, t.timer_id, 1'b0, 1'b1);
                end else begin
                    pool_used[slot]     = 1'b1;
                    pool_ident[slot]    = t.timer_id;
                    pool_start[slot]    = now_cnt;
                    pool_timeout[slot]  = t.timeout_ticks;
                    pool_periodic[slot] = t.periodic;
                    pool_notify[slot]   = t.has_callback;
                    pool_cancel[slot]   = 1'b0;
                    add_result(tps_pkg::KIND_STARTED, t.timer_id, 1'b0, 1'b1);
                end
            end
            tps_pkg::MODE_CANCEL: begin
                slot = find_slot(t.timer_id);
                if (slot >= 0)
                    pool_cancel[slot] = 1'b1;
                add_result(tps_pkg::KIND_CANCEL, t.timer_id, slot >= 0, 1'b1);
            end
            tps_pkg::MODE_TICK: begin
                now_cnt = now_cnt + 32'd1;
                for (i = 0; i < tps_pkg::POOL_SLOTS; i++) begin
                    if (pool_used[i]) begin
                        elapsed = now_cnt - pool_start[i];
                        if (pool_cancel[i]) begin
                            pool_used[i] = 1'b0;
                        end else if (elapsed >= pool_timeout[i]) begin
                            if (pool_notify[i])
                                add_result(tps_pkg::KIND_FIRED, pool_ident[i],
                                           1'b0, 1'b0);
                            if (pool_periodic[i])
                                pool_start[i] = now_cnt;
                            else
                                pool_used[i] = 1'b0;
                        end
                    end
                end
                add_result(tps_pkg::KIND_SCAN, 8'd0, 1'b0, 1'b1);
            end
            default: begin
                // unused mode: ignored, no result
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_dir_row mk_row(logic [1:0] mode, logic [7:0] id,
                                        logic [31:0] tmo, logic per, logic cb,
                                        int rep, bit typed, logic [2:0] kind,
                                        logic [7:0] tid, logic found);
        t_dir_row r;
        r.txn.mode          = mode;
        r.txn.timer_id      = id;
        r.txn.timeout_ticks = tmo;
        r.txn.periodic      = per;
        r.txn.has_callback  = cb;
        r.txn.typed         = typed;
        r.txn.t_kind        = kind;
        r.txn.t_id          = tid;
        r.txn.t_found       = found;
        r.rep               = rep;
        return r;
    endfunction

    function automatic t_txn rand_txn();
        t_txn t;
        int   roll;
        roll = $urandom_range(99);
        if (roll < 45)      t.mode = tps_pkg::MODE_START;
        else if (roll < 60) t.mode = tps_pkg::MODE_CANCEL;
        else if (roll < 95) t.mode = tps_pkg::MODE_TICK;
        else                t.mode = tps_pkg::MODE_NONE;
        // mostly a small id set so that restarts, cancels and a full pool occur
        if ($urandom_range(99) < 80) t.timer_id = 8'($urandom_range(23));
        else                         t.timer_id = 8'($urandom_range(255));
        roll = $urandom_range(99);
        if (roll < 40)      t.timeout_ticks = $urandom_range(3);
        else if (roll < 70) t.timeout_ticks = $urandom_range(30, 4);
        else if (roll < 85) t.timeout_ticks = $urandom_range(32'hFFFF_FFFF, 32'hFFFF_0000);
        else                t.timeout_ticks = $urandom;
        t.periodic     = 1'($urandom_range(1));
        t.has_callback = 1'($urandom_range(1));
        t.typed        = 1'b0;
        t.t_kind       = tps_pkg::KIND_STARTED;
        t.t_id         = '0;
        t.t_found      = 1'b0;
        return t;
    endfunction

    // offers one transaction and books its expected results on acceptance
    task automatic send_txn(input t_txn t);
        int i;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_mode          <= t.mode;
        i_timer_id      <= t.timer_id;
        i_timeout_ticks <= t.timeout_ticks;
        i_periodic      <= t.periodic;
        i_has_callback  <= t.has_callback;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        pool_step(t);
        if (t.typed) begin
            pending_results.push_back('{t.t_kind, t.t_id, t.t_found, 1'b1});
        end else begin
            for (i = 0; i < step_results.size(); i++)
                pending_results.push_back(step_results[i]);
        end
    endtask

    // ------------------------------------------------------------------
    // output side: ready pattern with an optional long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // result check against the oldest pending expectation
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d id %0d found %0d last %0d",
                       o_kind, o_fired_id, o_found, o_last);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_kind !== e.kind) begin
                    $error("kind mismatch: expected %0d, actual %0d", e.kind, o_kind);
                    fail_count++;
                end
                if (o_fired_id !== e.fired_id) begin
                    $error("fired_id mismatch: expected %0d, actual %0d",
                           e.fired_id, o_fired_id);
                    fail_count++;
                end
                if (o_found !== e.found) begin
                    $error("found mismatch: expected %0d, actual %0d", e.found, o_found);
                    fail_count++;
                end
                if (o_last !== e.last) begin
                    $error("last mismatch: expected %0d, actual %0d", e.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_txn t;
        int   r;
        int   k;
        int   ph;
        int   sent;
        int   send_pct[4];
        int   recv_pct[4];

        send_pct = '{0, 64, 0, 16};
        recv_pct = '{0, 0, 64, 16};

        // tick on an empty pool, unknown cancel, plain starts at the extremes
        dir_tbl.push_back(mk_row(tps_pkg::MODE_TICK, 8'h00, 32'd0, 1'b0, 1'b0, 1,
                                 1'b1, tps_pkg::KIND_SCAN, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_CANCEL, 8'h55, 32'd0, 1'b0, 1'b0, 1,
                                 1'b1, tps_pkg::KIND_CANCEL, 8'h55, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_START, 8'h00, 32'd0, 1'b0, 1'b1, 1,
                                 1'b1, tps_pkg::KIND_STARTED, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_START, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1,
                                 1'b1, tps_pkg::KIND_STARTED, 8'hFF, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_START, 8'h12, 32'd2, 1'b1, 1'b1, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        // one-shot without callback is freed silently
        dir_tbl.push_back(mk_row(tps_pkg::MODE_START, 8'h34, 32'd1, 1'b0, 1'b0, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_TICK, 8'h00, 32'd0, 1'b0, 1'b0, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_TICK, 8'h00, 32'd0, 1'b0, 1'b0, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_CANCEL, 8'h12, 32'd0, 1'b0, 1'b0, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_CANCEL, 8'hFF, 32'd0, 1'b0, 1'b0, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        // restart of a known id drops its pending cancel
        dir_tbl.push_back(mk_row(tps_pkg::MODE_START, 8'hFF, 32'd1, 1'b0, 1'b1, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_NONE, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_TICK, 8'h00, 32'd0, 1'b0, 1'b0, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        // fill the pool with periodic zero-timeout timers
        dir_tbl.push_back(mk_row(tps_pkg::MODE_START, 8'h80, 32'd0, 1'b1, 1'b1,
                                 tps_pkg::POOL_SLOTS, 1'b0, 3'd0, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_START, 8'h90, 32'd5, 1'b0, 1'b1, 1,
                                 1'b1, tps_pkg::KIND_FULL, 8'h90, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_START, 8'h85, 32'hFFFF_FFF0, 1'b0, 1'b1, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        // wide burst: every slot but one fires
        dir_tbl.push_back(mk_row(tps_pkg::MODE_TICK, 8'h00, 32'd0, 1'b0, 1'b0, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_CANCEL, 8'h80, 32'd0, 1'b0, 1'b0,
                                 tps_pkg::POOL_SLOTS, 1'b0, 3'd0, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_TICK, 8'h00, 32'd0, 1'b0, 1'b0, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_TICK, 8'h00, 32'd0, 1'b0, 1'b0, 1,
                                 1'b1, tps_pkg::KIND_SCAN, 8'h00, 1'b0));
        // alternating bit patterns on the payload
        dir_tbl.push_back(mk_row(tps_pkg::MODE_START, 8'hAA, 32'h5555_5555, 1'b1, 1'b0, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_START, 8'h55, 32'hAAAA_AAAA, 1'b0, 1'b1, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_CANCEL, 8'hAA, 32'd0, 1'b0, 1'b0, 1,
                                 1'b1, tps_pkg::KIND_CANCEL, 8'hAA, 1'b1));
        dir_tbl.push_back(mk_row(tps_pkg::MODE_TICK, 8'h00, 32'd0, 1'b0, 1'b0, 1,
                                 1'b0, 3'd0, 8'h00, 1'b0));

        // reset
        clear_pool();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (r = 0; r < dir_tbl.size(); r++) begin
            for (k = 0; k < dir_tbl[r].rep; k++) begin
                t          = dir_tbl[r].txn;
                t.timer_id = t.timer_id + k[7:0];
                send_txn(t);
            end
        end

        // random traffic over the idle and stall patterns
        for (ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            // long output hold-off while the input keeps offering
            if (ph == 0)
                hold_pending = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                t = rand_txn();
                send_txn(t);
                if (t.mode != tps_pkg::MODE_NONE)
                    sent++;
            end
        end

        // drain
        i_valid        <= 1'b0;
        recv_stall_pct = 0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
